// ===== src/ipr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types, sizes and helpers of the isolated pixel removal filter.
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W = 8;
  localparam int DIM_W = 11;
  // counters address one line store entry and one frame row
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int CFG_ADDR_W = 1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // result queue, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // one column of the 3x3 window, top is the oldest row
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    pixel_t           pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } stage_t;

  // results caused by one input pixel: window result first, then own result
  typedef struct packed {
    logic             win_v;
    logic [ROW_W-1:0] win_row;
    logic [COL_W-1:0] win_col;
    pixel_t           win_pix;
    logic             own_v;
    logic [ROW_W-1:0] own_row;
    logic [COL_W-1:0] own_col;
    pixel_t           own_pix;
  } result_pair_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) r = MIN_DIM;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== src/ipr_in_if.sv =====
// ----------------------------------------------------------------------------
// ipr_in_if
// Pixel input channel: valid, ready and one grey value.
// ----------------------------------------------------------------------------
interface ipr_in_if;
  logic                     valid;
  logic                     ready;
  logic [ipr_pkg::PIX_W-1:0] pixel_in;

  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

// ===== src/ipr_out_if.sv =====
// ----------------------------------------------------------------------------
// ipr_out_if
// Result channel: valid, ready, position, filtered value and last marker.
// ----------------------------------------------------------------------------
interface ipr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ipr_pkg::ROW_W-1:0] out_row;
  logic [ipr_pkg::COL_W-1:0] out_col;
  logic [ipr_pkg::PIX_W-1:0] pixel_out;
  logic                      run_last;

  modport source(output valid, output out_row, output out_col, output pixel_out,
                 output run_last, input ready);
  modport sink(input valid, input out_row, input out_col, input pixel_out,
               input run_last, output ready);
endinterface

// ===== src/ipr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ipr_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface ipr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ipr_pkg::CFG_ADDR_W-1:0] addr;
  logic [ipr_pkg::DIM_W-1:0]      data;

  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface

// ===== src/ipr_ram.sv =====
// ----------------------------------------------------------------------------
// ipr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ipr_cell.sv =====
// ----------------------------------------------------------------------------
// ipr_cell
// One column of the 3x3 window; takes its neighbor's column on every shift.
// ----------------------------------------------------------------------------
module ipr_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  ipr_pkg::column_t col_in,
  output ipr_pkg::column_t col_out
);

  ipr_pkg::column_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

// ===== src/ipr_result_queue.sv =====
// ----------------------------------------------------------------------------
// ipr_result_queue
// Small queue of result pairs, drained one result per output transaction.
// ----------------------------------------------------------------------------
module ipr_result_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ipr_pkg::result_pair_t          push_data,
  output logic [ipr_pkg::QCNT_W-1:0]     count,
  ipr_out_if.source                      results
);

  ipr_pkg::result_pair_t store [ipr_pkg::QDEPTH];
  ipr_pkg::result_pair_t head;

  logic [ipr_pkg::QPTR_W-1:0] wr_ptr;
  logic [ipr_pkg::QPTR_W-1:0] rd_ptr;
  logic [ipr_pkg::QCNT_W-1:0] count_next;
  logic                       second;
  logic                       sel_win;
  logic                       pop_tx;
  logic                       done;

  assign head    = store[rd_ptr];
  assign sel_win = head.win_v && !second;
  assign pop_tx  = results.valid && results.ready;
  // a pair holding two results leaves after its second transaction
  assign done    = pop_tx && !(sel_win && head.own_v);

  always_comb begin
    count_next = count;
    if (push && !done) begin
      count_next = count + ipr_pkg::QCNT_W'(1);
    end else if (!push && done) begin
      count_next = count - ipr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      second <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + ipr_pkg::QPTR_W'(1);
      end
      if (done) begin
        rd_ptr <= rd_ptr + ipr_pkg::QPTR_W'(1);
        second <= 1'b0;
      end else if (pop_tx) begin
        second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  assign results.valid     = (count != '0);
  assign results.out_row   = sel_win ? head.win_row : head.own_row;
  assign results.out_col   = sel_win ? head.win_col : head.own_col;
  assign results.pixel_out = sel_win ? head.win_pix : head.own_pix;
  assign results.run_last  = !(sel_win && head.own_v);

endmodule

// ===== src/isolated_pixel_removal.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_removal
// Streaming 3x3 isolated pixel filter over two line stores and a chain of
// three window column cells. Border pixels pass through unchanged.
// Path: each pixel passes stage 1, stage 2 and then the result queue.
// Throughput: one pixel per cycle while the result queue has room; a pixel on
//   the last row or last column that also completes a window gives two results
//   in two output transactions, so along the last row the input is held back.
// Reset: counters cleared, width 640 and height 480, window cleared; the line
//   stores are not cleared and hold stale data until written.
// ----------------------------------------------------------------------------
module isolated_pixel_removal (
  input  logic      clk,
  input  logic      rst,
  ipr_cfg_if.sink   cfg,
  ipr_in_if.sink    pixels,
  ipr_out_if.source results
);

  logic [ipr_pkg::DIM_W-1:0] frame_width;
  logic [ipr_pkg::DIM_W-1:0] frame_height;
  logic [ipr_pkg::ROW_W-1:0] row_count;
  logic [ipr_pkg::COL_W-1:0] col_count;

  logic                       accept;
  logic                       last_col;
  logic                       last_row;
  logic [ipr_pkg::QCNT_W-1:0] q_count;
  logic [ipr_pkg::QCNT_W-1:0] in_flight;

  logic            s1_valid;
  ipr_pkg::stage_t s1;
  logic            s2_valid;
  ipr_pkg::stage_t s2;

  ipr_pkg::pixel_t  older_rdata;
  ipr_pkg::pixel_t  newer_rdata;
  ipr_pkg::column_t new_col;
  ipr_pkg::column_t col0;
  ipr_pkg::column_t col1;
  ipr_pkg::column_t col2;

  logic                  any_near;
  logic                  border;
  ipr_pkg::pixel_t       filtered;
  ipr_pkg::result_pair_t pair;
  logic                  push;

  // configuration, kept as clamped effective sizes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ipr_pkg::RESET_WIDTH;
      frame_height <= ipr_pkg::RESET_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.addr)
        ipr_pkg::REG_FRAME_WIDTH: begin
          frame_width <= ipr_pkg::clamp_dim(cfg.data,
                                            ipr_pkg::DIM_W'(ipr_pkg::MAX_WIDTH));
        end
        ipr_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= ipr_pkg::clamp_dim(cfg.data,
                                             ipr_pkg::DIM_W'(ipr_pkg::MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  // accept only while the queue can absorb every pixel still in the pipe
  assign in_flight = q_count + ipr_pkg::QCNT_W'(s1_valid) + ipr_pkg::QCNT_W'(s2_valid);
  assign pixels.ready = (in_flight < ipr_pkg::QCNT_W'(ipr_pkg::QDEPTH));
  assign accept = pixels.valid && pixels.ready;

  assign last_col = (ipr_pkg::DIM_W'(col_count) + ipr_pkg::DIM_W'(1)) >= frame_width;
  assign last_row = (ipr_pkg::DIM_W'(row_count) + ipr_pkg::DIM_W'(1)) >= frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ipr_pkg::ROW_W'(1);
      end else begin
        col_count <= col_count + ipr_pkg::COL_W'(1);
      end
    end
  end

  // stage 1: line store read data arrives, stores are updated
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pix  <= pixels.pixel_in;
      s1.row  <= row_count;
      s1.col  <= col_count;
      s1.last <= last_col || last_row;
    end
    if (s1_valid) begin
      s2 <= s1;
    end
  end

  ipr_ram #(
    .WIDTH(ipr_pkg::PIX_W),
    .DEPTH(ipr_pkg::MAX_WIDTH)
  ) u_older_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1.col),
    .wdata(newer_rdata),
    .re   (accept),
    .raddr(col_count),
    .rdata(older_rdata)
  );

  ipr_ram #(
    .WIDTH(ipr_pkg::PIX_W),
    .DEPTH(ipr_pkg::MAX_WIDTH)
  ) u_newer_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1.col),
    .wdata(s1.pix),
    .re   (accept),
    .raddr(col_count),
    .rdata(newer_rdata)
  );

  // window: new column enters cell 2 and moves toward cell 0
  assign new_col = '{top: older_rdata, mid: newer_rdata, bot: s1.pix};

  ipr_cell u_cell2 (.clk(clk), .rst(rst), .shift(s1_valid), .col_in(new_col),
                    .col_out(col2));
  ipr_cell u_cell1 (.clk(clk), .rst(rst), .shift(s1_valid), .col_in(col2),
                    .col_out(col1));
  ipr_cell u_cell0 (.clk(clk), .rst(rst), .shift(s1_valid), .col_in(col1),
                    .col_out(col0));

  // stage 2: window holds the state after this pixel
  assign any_near = (col0.top != '0) || (col0.mid != '0) || (col0.bot != '0) ||
                    (col1.top != '0) || (col1.bot != '0) ||
                    (col2.top != '0) || (col2.mid != '0) || (col2.bot != '0);
  assign filtered = ((col1.mid != '0) && any_near) ? ipr_pkg::PIX_MAX : '0;
  assign border   = (s2.row == ipr_pkg::ROW_W'(1)) || (s2.col == ipr_pkg::COL_W'(1));

  always_comb begin
    pair.win_v   = (s2.row != '0) && (s2.col != '0);
    pair.win_row = s2.row - ipr_pkg::ROW_W'(1);
    pair.win_col = s2.col - ipr_pkg::COL_W'(1);
    pair.win_pix = border ? col1.mid : filtered;
    pair.own_v   = s2.last;
    pair.own_row = s2.row;
    pair.own_col = s2.col;
    pair.own_pix = s2.pix;
  end

  assign push = s2_valid && (pair.win_v || pair.own_v);

  ipr_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(pair),
    .count    (q_count),
    .results  (results)
  );

endmodule
